// ===== hw/rtl/nmea_rmc_sentence_parser_assert.svh =====
// Assertion macros shared by the RMC sentence parser RTL.
// Depends on nothing; included inside module bodies that check their logic.
`ifndef NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH
`define NMEA_RMC_SENTENCE_PARSER_ASSERT_SVH

// Condition holds in the same cycle as the antecedent.
`define NRMC_ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition holds in the cycle after the antecedent.
`define NRMC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/nrmc_pkg.sv =====
// Types, constants and small lookup functions for the RMC sentence parser.
// Depends on nothing; used by nrmc_coord_lane and nmea_rmc_sentence_parser.
package nrmc_pkg;

  // Characters recognized in the serial stream.
  localparam logic [7:0] CHAR_NL    = 8'h0A;
  localparam logic [7:0] CHAR_COMMA = 8'h2C;
  localparam logic [7:0] CHAR_POINT = 8'h2E;
  localparam logic [7:0] CHAR_0     = 8'h30;
  localparam logic [7:0] CHAR_9     = 8'h39;
  localparam logic [7:0] CHAR_A     = 8'h41;
  localparam logic [7:0] CHAR_N     = 8'h4E;
  localparam logic [7:0] CHAR_S     = 8'h53;
  localparam logic [7:0] CHAR_E     = 8'h45;
  localparam logic [7:0] CHAR_W     = 8'h57;

  // Field numbers within a sentence, counted in commas.
  localparam logic [3:0] FIELD_TIME     = 4'd1;
  localparam logic [3:0] FIELD_STATUS   = 4'd2;
  localparam logic [3:0] FIELD_LAT      = 4'd3;
  localparam logic [3:0] FIELD_LAT_HEMI = 4'd4;
  localparam logic [3:0] FIELD_LON      = 4'd5;
  localparam logic [3:0] FIELD_LON_HEMI = 4'd6;
  localparam logic [3:0] FIELD_COURSE   = 4'd8;
  localparam logic [3:0] FIELD_LAST     = 4'd15;

  // Kept fraction digits per number format.
  localparam logic [2:0] FRAC_COORD = 3'd5;
  localparam logic [2:0] FRAC_CENTI = 3'd2;
  localparam int         PREFIX_LEN = 6;

  // Hemisphere letter code.
  typedef enum logic [1:0] {
    HEMI_NONE = 2'd0,
    HEMI_POS  = 2'd1,
    HEMI_NEG  = 2'd2
  } hemi_t;

  // Coordinate conversion widths and constants.
  localparam int ACC_W       = 34;
  localparam int LAT_ACC_W   = 30;
  localparam int DEG_W       = 11;
  localparam int DEGP_W      = 35;
  localparam int REM_W       = 24;
  localparam int FRAC_W      = 24;
  localparam int SCALE_SHIFT = 7;
  localparam int RECIP_W     = 21;
  localparam int RECIP_SHIFT = 37;
  localparam int QUOT_W      = ACC_W - SCALE_SHIFT + RECIP_W;
  localparam int THIRD_IN_W  = REM_W + 3;
  localparam int THIRD_SHIFT = 33;
  localparam int THIRD_W     = THIRD_IN_W + 32;

  // 10^7 = 2^7 * 78125; the reciprocal of 78125 is scaled by 2^37.
  localparam logic [REM_W-1:0]   DEG_SCALE   = 24'd10000000;
  localparam logic [RECIP_W-1:0] DEG_RECIP   = 21'd1759218;
  localparam logic [31:0]        THIRD_RECIP = 32'hAAAAAAAB;

  localparam logic [30:0] LAT_LIMIT = 31'd900000000;
  localparam logic [30:0] LON_LIMIT = 31'd1800000000;

  // Stage advance strobes for the coordinate lanes.
  typedef struct packed {
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } stage_en_t;

  // Record fields that ride alongside the coordinate lanes.
  typedef struct packed {
    logic [26:0] utc_time;
    logic        time_valid;
    hemi_t       lat_hemi;
    hemi_t       lon_hemi;
    logic [15:0] course;
    logic        course_valid;
  } rec_side_t;

  // Powers of ten used to place a digit.
  function automatic logic [16:0] pow10(input logic [2:0] exp);
    logic [16:0] val;
    case (exp)
      3'd0:    val = 17'd1;
      3'd1:    val = 17'd10;
      3'd2:    val = 17'd100;
      3'd3:    val = 17'd1000;
      3'd4:    val = 17'd10000;
      3'd5:    val = 17'd100000;
      default: val = 17'd0;
    endcase
    return val;
  endfunction

  // Expected characters of the sentence tag.
  function automatic logic [7:0] prefix_char(input logic [2:0] idx);
    logic [7:0] ch;
    case (idx)
      3'd0:    ch = 8'h24;
      3'd1:    ch = 8'h47;
      3'd2:    ch = 8'h50;
      3'd3:    ch = 8'h52;
      3'd4:    ch = 8'h4D;
      3'd5:    ch = 8'h43;
      default: ch = 8'h00;
    endcase
    return ch;
  endfunction

endpackage

// ===== hw/rtl/nmea_rmc_sentence_parser.sv =====
// Top level of the RMC sentence parser: byte parser and record pipeline.
// Depends on nrmc_pkg, nrmc_coord_lane and nmea_rmc_sentence_parser_assert.svh.
//
// Usage:
//   The input channel carries one received character per beat on rx_byte.
//   A line ends at a newline or at its LINE_MAX-th byte. A line that opens
//   with $GPRMC yields one record beat on the output channel; any other
//   line yields nothing. The record carries time, latitude, longitude and
//   course, each with its valid bit; a value is zero when its bit is low.
//   Throughput is one byte per cycle while in_stall is low. A record passes
//   the six-register conversion pipeline (capture, degree estimate,
//   back-multiply, remainder correction, minute scaling, output register)
//   after the beat that ends its line. The pipeline holds up to six records;
//   when the receiver stalls, records queue in it and the input stalls only
//   once every stage is full. Stages that hold nothing close up at once.
//   A synchronous reset clears the line state and drops any record in
//   flight; the block takes bytes in the first cycle after reset.
module nmea_rmc_sentence_parser #(
  parameter int LINE_MAX = 128
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [7:0]         rx_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [26:0]        utc_time,
  output logic               time_valid,
  output logic signed [30:0] latitude,
  output logic               latitude_valid,
  output logic signed [31:0] longitude,
  output logic               longitude_valid,
  output logic [15:0]        course,
  output logic               course_valid
);
  import nrmc_pkg::*;

  `include "nmea_rmc_sentence_parser_assert.svh"

  localparam int LEN_W = $clog2(LINE_MAX);
  localparam int NUM_W = 38;

  localparam logic [NUM_W-1:0] TIME_CAP   = 38'd99999999;
  localparam logic [NUM_W-1:0] LAT_CAP    = 38'h003FFFFFFF;
  localparam logic [NUM_W-1:0] LON_CAP    = 38'h03FFFFFFFF;
  localparam logic [NUM_W-1:0] COURSE_CAP = 38'h000001FFFF;

  // One digit into an accumulator, saturating at its cap.
  function automatic logic [NUM_W-1:0] num_step(
    input logic [NUM_W-1:0] acc,
    input logic             int_part,
    input logic [19:0]      term,
    input logic [NUM_W-1:0] cap
  );
    logic [NUM_W-1:0] sum;
    sum = (int_part ? ((acc << 3) + (acc << 1)) : acc) + NUM_W'(term);
    return (sum > cap) ? cap : sum;
  endfunction

  // Final coordinate word: sum, clamp, sign by hemisphere.
  function automatic logic [31:0] coord_out(
    input logic [DEGP_W-1:0] degp,
    input logic [FRAC_W-1:0] frac,
    input hemi_t             hemi,
    input logic [30:0]       limit
  );
    logic [DEGP_W:0] mag;
    logic [31:0]     sat;
    logic [31:0]     res;
    mag = (DEGP_W+1)'(degp) + (DEGP_W+1)'(frac);
    sat = (mag > (DEGP_W+1)'(limit)) ? 32'(limit) : mag[31:0];
    case (hemi)
      HEMI_POS: res = sat;
      HEMI_NEG: res = 32'd0 - sat;
      default:  res = 32'd0;
    endcase
    return res;
  endfunction

  // Line parser state.
  logic [LEN_W-1:0]     line_length;
  logic [3:0]           field_index;
  logic                 prefix_matches;
  logic                 status_active;
  logic                 number_stopped;
  logic                 point_seen;
  logic [2:0]           fraction_digits;
  logic [26:0]          time_acc;
  logic [LAT_ACC_W-1:0] lat_acc;
  logic [ACC_W-1:0]     lon_acc;
  logic [16:0]          course_acc;
  hemi_t                lat_hemi;
  hemi_t                lon_hemi;
  logic                 course_present;

  // State after this byte, before any end-of-line clear.
  logic [3:0]           field_upd;
  logic                 prefix_upd;
  logic                 status_upd;
  logic                 stopped_upd;
  logic                 point_upd;
  logic [2:0]           frac_upd;
  logic [26:0]          time_upd;
  logic [LAT_ACC_W-1:0] lat_upd;
  logic [ACC_W-1:0]     lon_upd;
  logic [16:0]          course_upd;
  hemi_t                lat_hemi_upd;
  hemi_t                lon_hemi_upd;
  logic                 course_present_upd;

  logic                 in_fire;
  logic                 is_nl;
  logic                 is_comma;
  logic                 is_digit;
  logic [3:0]           digit;
  logic                 numeric;
  logic [2:0]           frac_max;
  logic                 take_digit;
  logic [2:0]           term_exp;
  logic [20:0]          term_full;
  logic [19:0]          term;
  logic [LEN_W:0]       len_inc;
  logic                 line_end;
  logic                 emit;

  // Record pipeline.
  logic [5:1]           s_valid;
  logic [5:1]           ready;
  logic                 out_ready;
  rec_side_t            side_in;
  rec_side_t            side [1:5];
  logic [ACC_W-1:0]     lat1;
  logic [ACC_W-1:0]     lon1;
  stage_en_t            stage_en;
  logic [DEGP_W-1:0]    lat_deg;
  logic [FRAC_W-1:0]    lat_frac;
  logic [DEGP_W-1:0]    lon_deg;
  logic [FRAC_W-1:0]    lon_frac;
  logic [31:0]          lat_word;
  logic [31:0]          lon_word;

  assign in_stall = !ready[1];
  assign in_fire  = in_valid && !in_stall;

  // Byte classification and digit placement.
  assign is_nl      = (rx_byte == CHAR_NL);
  assign is_comma   = (rx_byte == CHAR_COMMA);
  assign is_digit   = (rx_byte >= CHAR_0) && (rx_byte <= CHAR_9);
  assign digit      = rx_byte[3:0];
  assign numeric    = (field_index == FIELD_TIME) || (field_index == FIELD_LAT) ||
                      (field_index == FIELD_LON) || (field_index == FIELD_COURSE);
  assign frac_max   = ((field_index == FIELD_LAT) || (field_index == FIELD_LON)) ?
                      FRAC_COORD : FRAC_CENTI;
  assign take_digit = !number_stopped && is_digit &&
                      (!point_seen || (fraction_digits < frac_max));
  assign term_exp   = point_seen ? (frac_max - fraction_digits - 3'd1) : frac_max;
  assign term_full  = 21'(digit) * 21'(pow10(term_exp));
  assign term       = term_full[19:0];

  // Line end: newline, or the byte that reaches the length limit.
  assign len_inc  = (LEN_W+1)'(line_length) + (LEN_W+1)'(1);
  assign line_end = is_nl || (len_inc >= (LEN_W+1)'(LINE_MAX));
  assign emit     = line_end && prefix_upd;

  // Per-byte field update.
  always_comb begin
    field_upd          = field_index;
    prefix_upd         = prefix_matches;
    status_upd         = status_active;
    stopped_upd        = number_stopped;
    point_upd          = point_seen;
    frac_upd           = fraction_digits;
    time_upd           = time_acc;
    lat_upd            = lat_acc;
    lon_upd            = lon_acc;
    course_upd         = course_acc;
    lat_hemi_upd       = lat_hemi;
    lon_hemi_upd       = lon_hemi;
    course_present_upd = course_present;

    if ((line_length < LEN_W'(PREFIX_LEN)) && (rx_byte != prefix_char(line_length[2:0]))) begin
      prefix_upd = 1'b0;
    end

    if (!is_nl && is_comma) begin
      if (field_index != FIELD_LAST) begin
        field_upd = field_index + 4'd1;
      end
      stopped_upd = 1'b0;
      point_upd   = 1'b0;
      frac_upd    = 3'd0;
    end else if (!is_nl) begin
      // Shared number flags for the numeric fields.
      if (numeric && !number_stopped) begin
        if (is_digit) begin
          if (take_digit && point_seen) begin
            frac_upd = fraction_digits + 3'd1;
          end
        end else if ((rx_byte == CHAR_POINT) && !point_seen) begin
          point_upd = 1'b1;
        end else begin
          stopped_upd = 1'b1;
        end
      end

      unique case (field_index)
        FIELD_TIME: begin
          if (take_digit) begin
            time_upd = 27'(num_step(NUM_W'(time_acc), !point_seen, term, TIME_CAP));
          end
        end
        FIELD_LAT: begin
          if (take_digit) begin
            lat_upd = LAT_ACC_W'(num_step(NUM_W'(lat_acc), !point_seen, term, LAT_CAP));
          end
        end
        FIELD_LON: begin
          if (take_digit) begin
            lon_upd = ACC_W'(num_step(NUM_W'(lon_acc), !point_seen, term, LON_CAP));
          end
        end
        FIELD_COURSE: begin
          course_present_upd = 1'b1;
          if (take_digit) begin
            course_upd = 17'(num_step(NUM_W'(course_acc), !point_seen, term, COURSE_CAP));
          end
        end
        FIELD_STATUS: begin
          if (!number_stopped) begin
            status_upd = (rx_byte == CHAR_A);
          end
          stopped_upd = 1'b1;
        end
        FIELD_LAT_HEMI: begin
          if (!number_stopped) begin
            lat_hemi_upd = (rx_byte == CHAR_N) ? HEMI_POS :
                           (rx_byte == CHAR_S) ? HEMI_NEG : HEMI_NONE;
          end
          stopped_upd = 1'b1;
        end
        FIELD_LON_HEMI: begin
          if (!number_stopped) begin
            lon_hemi_upd = (rx_byte == CHAR_E) ? HEMI_POS :
                           (rx_byte == CHAR_W) ? HEMI_NEG : HEMI_NONE;
          end
          stopped_upd = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // Parser registers; every finished line returns them to reset values.
  always_ff @(posedge clk) begin
    if (rst) begin
      line_length     <= '0;
      field_index     <= '0;
      prefix_matches  <= 1'b1;
      status_active   <= 1'b0;
      number_stopped  <= 1'b0;
      point_seen      <= 1'b0;
      fraction_digits <= '0;
      time_acc        <= '0;
      lat_acc         <= '0;
      lon_acc         <= '0;
      course_acc      <= '0;
      lat_hemi        <= HEMI_NONE;
      lon_hemi        <= HEMI_NONE;
      course_present  <= 1'b0;
    end else if (in_fire) begin
      if (line_end) begin
        line_length     <= '0;
        field_index     <= '0;
        prefix_matches  <= 1'b1;
        status_active   <= 1'b0;
        number_stopped  <= 1'b0;
        point_seen      <= 1'b0;
        fraction_digits <= '0;
        time_acc        <= '0;
        lat_acc         <= '0;
        lon_acc         <= '0;
        course_acc      <= '0;
        lat_hemi        <= HEMI_NONE;
        lon_hemi        <= HEMI_NONE;
        course_present  <= 1'b0;
      end else begin
        line_length     <= len_inc[LEN_W-1:0];
        field_index     <= field_upd;
        prefix_matches  <= prefix_upd;
        status_active   <= status_upd;
        number_stopped  <= stopped_upd;
        point_seen      <= point_upd;
        fraction_digits <= frac_upd;
        time_acc        <= time_upd;
        lat_acc         <= lat_upd;
        lon_acc         <= lon_upd;
        course_acc      <= course_upd;
        lat_hemi        <= lat_hemi_upd;
        lon_hemi        <= lon_hemi_upd;
        course_present  <= course_present_upd;
      end
    end
  end

  // Record fields that need no further conversion.
  always_comb begin
    side_in.utc_time     = status_upd ? time_upd : 27'd0;
    side_in.time_valid   = status_upd;
    side_in.lat_hemi     = lat_hemi_upd;
    side_in.lon_hemi     = lon_hemi_upd;
    side_in.course_valid = course_present_upd;
    if (!course_present_upd) begin
      side_in.course = 16'd0;
    end else if (course_upd[16]) begin
      side_in.course = 16'hFFFF;
    end else begin
      side_in.course = course_upd[15:0];
    end
  end

  // Stage ready chain; empty stages close up.
  assign out_ready = !out_valid || !out_stall;

  always_comb begin
    ready[5] = !s_valid[5] || out_ready;
    for (int k = 4; k >= 1; k--) begin
      ready[k] = !s_valid[k] || ready[k+1];
    end
  end

  assign stage_en = '{s2: ready[2], s3: ready[3], s4: ready[4], s5: ready[5]};

  // Pipeline valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid   <= '0;
      out_valid <= 1'b0;
    end else begin
      if (out_ready) begin
        out_valid <= s_valid[5];
      end
      for (int k = 5; k >= 2; k--) begin
        if (ready[k]) begin
          s_valid[k] <= s_valid[k-1];
        end
      end
      if (ready[1]) begin
        s_valid[1] <= in_fire && emit;
      end
    end
  end

  // Pipeline payload.
  always_ff @(posedge clk) begin
    if (ready[1]) begin
      side[1] <= side_in;
      lat1    <= ACC_W'(lat_upd);
      lon1    <= lon_upd;
    end
    for (int k = 2; k <= 5; k++) begin
      if (ready[k]) begin
        side[k] <= side[k-1];
      end
    end
  end

  nrmc_coord_lane u_lat_lane (
    .clk       (clk),
    .en        (stage_en),
    .acc       (lat1),
    .deg_part  (lat_deg),
    .frac_part (lat_frac)
  );

  nrmc_coord_lane u_lon_lane (
    .clk       (clk),
    .en        (stage_en),
    .acc       (lon1),
    .deg_part  (lon_deg),
    .frac_part (lon_frac)
  );

  assign lat_word = coord_out(lat_deg, lat_frac, side[5].lat_hemi, LAT_LIMIT);
  assign lon_word = coord_out(lon_deg, lon_frac, side[5].lon_hemi, LON_LIMIT);

  // Output register.
  always_ff @(posedge clk) begin
    if (out_ready) begin
      utc_time        <= side[5].utc_time;
      time_valid      <= side[5].time_valid;
      latitude        <= lat_word[30:0];
      latitude_valid  <= (side[5].lat_hemi != HEMI_NONE);
      longitude       <= lon_word;
      longitude_valid <= (side[5].lon_hemi != HEMI_NONE);
      course          <= side[5].course;
      course_valid    <= side[5].course_valid;
    end
  end

  // Checks.
  `NRMC_ASSERT_HOLDS(a_len_in_range, clk, rst, 1'b1, line_length < LEN_W'(LINE_MAX - 1) || line_length == LEN_W'(LINE_MAX - 1), "line length past limit")
  `NRMC_ASSERT_HOLDS(a_field0_clear, clk, rst, field_index == 4'd0, time_acc == '0 && lat_acc == '0 && lon_acc == '0 && course_acc == '0, "accumulator set before first comma")
  `NRMC_ASSERT_HOLDS(a_frac_bound, clk, rst, 1'b1, fraction_digits <= FRAC_COORD, "too many fraction digits")
  `NRMC_ASSERT_NEXT(a_emit_loads, clk, rst, in_fire && emit, s_valid[1], "record lost at capture")
  `NRMC_ASSERT_NEXT(a_line_clears, clk, rst, in_fire && line_end, line_length == '0 && field_index == 4'd0 && prefix_matches, "line state not cleared")
  `NRMC_ASSERT_HOLDS(a_lat_range, clk, rst, out_valid, latitude >= -31'sd900000000 && latitude <= 31'sd900000000 && (latitude_valid || latitude == 31'sd0), "latitude out of range")

endmodule

// ===== hw/rtl/nrmc_coord_lane.sv =====
// Coordinate lane: splits a ddmm.mmmmm accumulator into whole-degree and
// minute parts over four stages. Depends on nrmc_pkg.
module nrmc_coord_lane (
  input  logic                            clk,
  input  nrmc_pkg::stage_en_t             en,
  input  logic [nrmc_pkg::ACC_W-1:0]      acc,
  output logic [nrmc_pkg::DEGP_W-1:0]     deg_part,
  output logic [nrmc_pkg::FRAC_W-1:0]     frac_part
);
  import nrmc_pkg::*;

  logic [QUOT_W-1:0]     quot_prod;
  logic [ACC_W-1:0]      acc2;
  logic [ACC_W-1:0]      acc3;
  logic [DEG_W-1:0]      deg_est;
  logic [DEGP_W-1:0]     prod3;
  logic [DEGP_W-1:0]     diff;
  logic                  over;
  logic [DEGP_W-1:0]     degp4;
  logic [REM_W-1:0]      rem4;
  logic [THIRD_IN_W-1:0] rem_x5;
  logic [THIRD_W-1:0]    third_prod;

  // Stage 2: degree estimate by reciprocal multiply, low by at most one.
  assign quot_prod = QUOT_W'(acc[ACC_W-1:SCALE_SHIFT]) * QUOT_W'(DEG_RECIP);

  always_ff @(posedge clk) begin
    if (en.s2) begin
      acc2    <= acc;
      deg_est <= DEG_W'(quot_prod >> RECIP_SHIFT);
    end
  end

  // Stage 3: estimated degrees back in accumulator units.
  always_ff @(posedge clk) begin
    if (en.s3) begin
      acc3  <= acc2;
      prod3 <= DEGP_W'(deg_est) * DEGP_W'(DEG_SCALE);
    end
  end

  // Stage 4: remainder with the one-step correction.
  assign diff = DEGP_W'(acc3) - prod3;
  assign over = (diff >= DEGP_W'(DEG_SCALE));

  always_ff @(posedge clk) begin
    if (en.s4) begin
      if (over) begin
        rem4  <= REM_W'(diff - DEGP_W'(DEG_SCALE));
        degp4 <= prod3 + DEGP_W'(DEG_SCALE);
      end else begin
        rem4  <= REM_W'(diff);
        degp4 <= prod3;
      end
    end
  end

  // Stage 5: minutes to degrees, floor(rem * 5 / 3) by reciprocal of three.
  assign rem_x5     = (THIRD_IN_W'(rem4) << 2) + THIRD_IN_W'(rem4);
  assign third_prod = THIRD_W'(rem_x5) * THIRD_W'(THIRD_RECIP);

  always_ff @(posedge clk) begin
    if (en.s5) begin
      deg_part  <= degp4;
      frac_part <= FRAC_W'(third_prod >> THIRD_SHIFT);
    end
  end

endmodule
